// ----- design/glvis_pkg.sv -----
// shared types and constants for the glen viscosity pipeline
// payload structs, register codes and the exp2 root constant function
// no dependencies
package glvis_pkg;

	typedef struct packed {
		logic signed [31:0] du_dx;
		logic signed [31:0] du_dy;
		logic signed [31:0] du_dz;
		logic signed [31:0] dv_dx;
		logic signed [31:0] dv_dy;
		logic signed [31:0] dv_dz;
		logic signed [31:0] dw_dx;
		logic signed [31:0] dw_dy;
		logic signed [31:0] dw_dz;
	} grad_t;

	typedef struct packed {
		logic [47:0] viscosity;
		logic [31:0] density_out;
	} visc_t;

	// signed q.16 log width: 8 integer bits, 16 fraction bits
	localparam int LOG_W  = 24;
	localparam int MANT_W = 31;

	localparam logic [47:0] VISC_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] VISC_FLOOR = 48'd1678;

	localparam logic [1:0] REG_FLUIDITY = 2'd0;
	localparam logic [1:0] REG_FLOW_EXP = 2'd1;
	localparam logic [1:0] REG_SR_FLOOR = 2'd2;
	localparam logic [1:0] REG_DENSITY  = 2'd3;

	localparam logic [31:0] FLUIDITY_RST = 32'd4915200;
	localparam logic [15:0] FLOW_EXP_RST = 16'd768;
	localparam logic [31:0] SR_FLOOR_RST = 32'd25684;
	localparam logic [31:0] DENSITY_RST  = 32'd60096512;

	// 2^(2^-k) in q1.30 by repeated integer square roots, elaboration only
	function automatic logic [30:0] root_const(input int k);
		logic [63:0] c;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		c = 64'd0;
		for (int j = 0; j < k; j++) begin
			v   = (j == 0) ? (64'd1 << 61) : (c << 30);
			res = 64'd0;
			b   = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			c = res;
		end
		return c[30:0];
	endfunction

endpackage

// ----- design/glvis_log2.sv -----
// pipelined log2 in signed q.16: leading one, normalise, then one squaring step per stage
// depends on glvis_pkg
module glvis_log2 #(
	parameter int XW = 70,
	parameter int B  = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [XW-1:0]                 x,
	input  logic [6:0]                    scale,
	output logic                          out_valid,
	output logic signed [glvis_pkg::LOG_W-1:0] lg
);

	localparam int PW = $clog2(XW);

	logic [PW-1:0] p_c;
	logic [PW-1:0] p_s0;
	logic [XW-1:0] x_s0;
	logic [6:0]    scale_s0;
	logic          v_s0;
	logic [XW+29:0] xs_c;

	logic [30:0]  m_s    [0:B];
	logic [B-1:0] bits_s [0:B];
	logic [7:0]   int_s  [0:B];
	logic         v_s    [0:B];

	// leading one
	always_comb begin
		p_c = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) p_c = PW'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s0     <= p_c;
			x_s0     <= x;
			scale_s0 <= scale;
		end
	end

	// bring the top set bit to bit 30
	assign xs_c = {x_s0, 30'b0} >> p_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= xs_c[30:0];
			bits_s[0] <= '0;
			int_s[0]  <= 8'(p_s0) - 8'(scale_s0);
		end
	end

	for (genvar k = 0; k < B; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = m_s[k] * m_s[k];
		assign t  = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k+1]    <= t[31] ? t[31:1] : t[30:0];
				bits_s[k+1] <= {bits_s[k][B-2:0], t[31]};
				int_s[k+1]  <= int_s[k];
			end
		end
	end

	assign out_valid = v_s[B];
	assign lg = $signed({int_s[B], bits_s[B], {(16-B){1'b0}}});

endmodule

// ----- design/glvis_div.sv -----
// pipelined floor division of a signed numerator by a positive 16 bit divisor
// two restoring steps per stage; no dependencies
module glvis_div #(
	parameter int SW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [32:0]   num,
	input  logic [15:0]          den,
	input  logic [SW-1:0]        side,
	output logic                 out_valid,
	output logic signed [34:0]   quo,
	output logic [SW-1:0]        side_out
);

	localparam int STG = 17;

	logic [33:0]   a_s    [0:STG];
	logic [15:0]   r_s    [0:STG];
	logic [33:0]   q_s    [0:STG];
	logic          neg_s  [0:STG];
	logic [SW-1:0] side_s [0:STG];
	logic          v_s    [0:STG];

	logic signed [34:0] quo_q;
	logic [SW-1:0]      side_q;
	logic               valid_q;

	assign a_s[0]    = num[32] ? 34'(-{num[32], num}) : 34'({num[32], num});
	assign r_s[0]    = '0;
	assign q_s[0]    = '0;
	assign neg_s[0]  = num[32];
	assign side_s[0] = side;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < STG; k++) begin : g_stage
		logic [33:0] a_n;
		logic [15:0] r_n;
		logic [33:0] q_n;
		logic [16:0] r2;

		always_comb begin
			a_n = a_s[k];
			r_n = r_s[k];
			q_n = q_s[k];
			r2  = '0;
			for (int j = 0; j < 2; j++) begin
				r2  = {r_n, a_n[33]};
				a_n = {a_n[32:0], 1'b0};
				if (r2 >= {1'b0, den}) begin
					r_n = 16'(r2 - {1'b0, den});
					q_n = {q_n[32:0], 1'b1};
				end else begin
					r_n = r2[15:0];
					q_n = {q_n[32:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k+1]    <= a_n;
				r_s[k+1]    <= r_n;
				q_s[k+1]    <= q_n;
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// round toward minus infinity for a negative numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_s[STG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q  <= neg_s[STG]
				? $signed(35'(-{1'b0, q_s[STG]}) - 35'(r_s[STG] != 16'd0))
				: $signed({1'b0, q_s[STG]});
			side_q <= side_s[STG];
		end
	end

	assign out_valid = valid_q;
	assign quo       = quo_q;
	assign side_out  = side_q;

endmodule

// ----- design/glvis_exp2.sv -----
// pipelined exp2 mantissa: one root constant multiply per fraction bit and stage
// depends on glvis_pkg (root_const)
module glvis_exp2 #(
	parameter int B = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [B-1:0]        g,
	input  logic signed [19:0]  ip,
	output logic                out_valid,
	output logic [30:0]         mant,
	output logic signed [19:0]  ip_out
);

	logic [30:0]        mm_s [0:B];
	logic [B-1:0]       g_s  [0:B];
	logic signed [19:0] ip_s [0:B];
	logic               v_s  [0:B];

	assign mm_s[0] = 31'h4000_0000;
	assign g_s[0]  = g;
	assign ip_s[0] = ip;
	assign v_s[0]  = in_valid;

	for (genvar k = 1; k <= B; k++) begin : g_mul
		localparam logic [30:0] CK = glvis_pkg::root_const(k);
		logic [61:0] prod;
		assign prod = mm_s[k-1] * CK;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mm_s[k] <= g_s[k-1][B-k] ? prod[60:30] : mm_s[k-1];
				g_s[k]  <= g_s[k-1];
				ip_s[k] <= ip_s[k-1];
			end
		end
	end

	assign out_valid = v_s[B];
	assign mant      = mm_s[B];
	assign ip_out    = ip_s[B];

endmodule

// ----- design/glen_viscosity_from_gradients_top.sv -----
// top level of the glen viscosity pipeline: config registers, strain-rate stages,
// log2 lanes, divider, exp2 and output shaping; depends on glvis_pkg and all glvis_ modules
//
//  channel  | direction | handshake                     | payload
//  grad     | in        | grad_valid / grad_stall       | glvis_pkg::grad_t, nine q16.16 gradients
//  visc     | out       | visc_valid / visc_stall       | glvis_pkg::visc_t, q24.24 viscosity, density
//  config   | in        | psel penable pwrite pready    | paddr, pwdata, prdata (32 bit)
//
// one transaction per cycle while a held output does not stall the pipeline; for B table bits there are
// 28 fixed stages plus two B-deep chains: log2 squaring and exp2 multiplies
// the pipeline moves as one: it halts only while a finished result waits and visc_stall is high
// reset clears every valid bit and loads the register reset values; no clearing pass
module glen_viscosity_from_gradients_top #(
	parameter int GRAD_FRAC_BITS      = 16,
	parameter int POW_TABLE_ADDR_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               grad_valid,
	output logic               grad_stall,
	input  glvis_pkg::grad_t   grad,
	output logic               visc_valid,
	input  logic               visc_stall,
	output glvis_pkg::visc_t   visc,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int B       = POW_TABLE_ADDR_BITS;
	localparam int TW      = 70;
	localparam int CW      = TW + 32;
	localparam int SCALE_T = 2 * GRAD_FRAC_BITS + 2;
	localparam int LW      = glvis_pkg::LOG_W;

	// configuration registers
	logic [31:0] fluidity_q;
	logic [15:0] flow_exp_q;
	logic [31:0] sr_floor_q;
	logic [31:0] density_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fluidity_q <= glvis_pkg::FLUIDITY_RST;
			flow_exp_q <= glvis_pkg::FLOW_EXP_RST;
			sr_floor_q <= glvis_pkg::SR_FLOOR_RST;
			density_q  <= glvis_pkg::DENSITY_RST;
		end else if (wr) begin
			case (paddr[3:2])
				glvis_pkg::REG_FLUIDITY: fluidity_q <= pwdata;
				glvis_pkg::REG_FLOW_EXP: flow_exp_q <= pwdata[15:0];
				glvis_pkg::REG_SR_FLOOR: sr_floor_q <= pwdata;
				glvis_pkg::REG_DENSITY:  density_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			glvis_pkg::REG_FLUIDITY: prdata = fluidity_q;
			glvis_pkg::REG_FLOW_EXP: prdata = {16'b0, flow_exp_q};
			glvis_pkg::REG_SR_FLOOR: prdata = sr_floor_q;
			glvis_pkg::REG_DENSITY:  prdata = density_q;
			default:                 prdata = '0;
		endcase
	end

	// degenerate register values: zero floor and zero fluidity act as one, n below one as one
	logic [31:0] fl_eff;
	logic [31:0] a_eff;
	logic [15:0] n_eff;
	assign fl_eff = (sr_floor_q == 32'd0) ? 32'd1 : sr_floor_q;
	assign a_eff  = (fluidity_q == 32'd0) ? 32'd1 : fluidity_q;
	assign n_eff  = (flow_exp_q < 16'd256) ? 16'd256 : flow_exp_q;

	// global advance: everything moves unless the output register is held
	logic               en;
	logic               visc_valid_q;
	glvis_pkg::visc_t   visc_q;

	assign en         = !(visc_valid_q && visc_stall);
	assign grad_stall = !en;

	// stage 1: input register
	glvis_pkg::grad_t g_s1;
	logic             valid_s1;

	// stage 2: shear sums and magnitudes (diagonals first)
	logic [32:0] mag_s2 [0:5];
	logic        valid_s2;

	// stage 3: squares
	logic [65:0] sq_s3 [0:5];
	logic        valid_s3;

	// stage 4: partial sums
	logic [67:0] dsum_s4;
	logic [67:0] ssum_s4;
	logic        valid_s4;

	// stage 5: four times the invariant
	logic [TW-1:0] t_s5;
	logic          valid_s5;

	// stage 6: floor selection
	logic [TW-1:0] x_s6;
	logic [6:0]    scale_s6;
	logic          valid_s6;

	function automatic logic [32:0] abs33(input logic [32:0] v);
		return v[32] ? 33'(-v) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= grad_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	logic below_c;
	assign below_c = {t_s5, 32'b0} < (CW'(fl_eff) << SCALE_T);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= grad;

			mag_s2[0] <= abs33({g_s1.du_dx[31], g_s1.du_dx});
			mag_s2[1] <= abs33({g_s1.dv_dy[31], g_s1.dv_dy});
			mag_s2[2] <= abs33({g_s1.dw_dz[31], g_s1.dw_dz});
			mag_s2[3] <= abs33({g_s1.du_dy[31], g_s1.du_dy} + {g_s1.dv_dx[31], g_s1.dv_dx});
			mag_s2[4] <= abs33({g_s1.du_dz[31], g_s1.du_dz} + {g_s1.dw_dx[31], g_s1.dw_dx});
			mag_s2[5] <= abs33({g_s1.dv_dz[31], g_s1.dv_dz} + {g_s1.dw_dy[31], g_s1.dw_dy});

			for (int i = 0; i < 6; i++) begin
				sq_s3[i] <= mag_s2[i] * mag_s2[i];
			end

			dsum_s4 <= 68'(sq_s3[0]) + 68'(sq_s3[1]) + 68'(sq_s3[2]);
			ssum_s4 <= 68'(sq_s3[3]) + 68'(sq_s3[4]) + 68'(sq_s3[5]);

			t_s5 <= TW'({dsum_s4, 1'b0}) + TW'(ssum_s4);

			x_s6     <= below_c ? TW'(fl_eff) : t_s5;
			scale_s6 <= below_c ? 7'd32 : 7'(SCALE_T);
		end
	end

	// log2 lanes: invariant and fluidity side by side, same depth
	logic                 lii_valid;
	logic                 la_valid;
	logic signed [LW-1:0] lii;
	logic signed [LW-1:0] la;

	glvis_log2 #(.XW(TW), .B(B)) u_log_ii (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s6), .x(x_s6), .scale(scale_s6),
		.out_valid(lii_valid), .lg(lii)
	);

	glvis_log2 #(.XW(32), .B(B)) u_log_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s6), .x(a_eff), .scale(7'd16),
		.out_valid(la_valid), .lg(la)
	);

	// exponent numerator (lii - 2 la) * 128, and the half-log term plus one
	logic signed [25:0]   diff_c;
	logic signed [32:0]   num_c;
	logic signed [LW-1:0] half_c;

	assign diff_c = 26'(lii) - (26'(la) <<< 1);
	assign num_c  = $signed({diff_c, 7'b0});
	assign half_c = (lii >>> 1) + LW'(65536);

	logic                 dv_valid;
	logic signed [34:0]   quo;
	logic [LW-1:0]        half_d;

	glvis_div #(.SW(LW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(lii_valid), .num(num_c), .den(n_eff), .side(half_c),
		.out_valid(dv_valid), .quo(quo), .side_out(half_d)
	);

	// exponent split into integer part and top fraction bits
	logic signed [35:0]  e_c;
	logic signed [19:0]  ip_s8;
	logic [B-1:0]        gf_s8;
	logic                valid_s8;

	assign e_c = 36'(quo) - 36'($signed(half_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ip_s8 <= e_c[35:16];
			gf_s8 <= e_c[15:16-B];
		end
	end

	logic               ex_valid;
	logic [30:0]        mant;
	logic signed [19:0] ip_x;

	glvis_exp2 #(.B(B)) u_exp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s8), .g(gf_s8), .ip(ip_s8),
		.out_valid(ex_valid), .mant(mant), .ip_out(ip_x)
	);

	// scale by 2^(ip-6), saturate, then apply the viscosity floor
	logic signed [20:0] ipm6_c;
	logic [4:0]         shr_c;
	logic [47:0]        vraw_c;
	logic [47:0]        vfin_c;

	assign ipm6_c = 21'(ip_x) - 21'sd6;
	assign shr_c  = 5'(-ipm6_c);

	always_comb begin
		if (ipm6_c >= 21'sd18) begin
			vraw_c = glvis_pkg::VISC_MAX;
		end else if (ipm6_c >= 21'sd0) begin
			vraw_c = {17'b0, mant} << ipm6_c[4:0];
		end else if (ipm6_c <= -21'sd31) begin
			vraw_c = '0;
		end else begin
			vraw_c = 48'(mant >> shr_c);
		end
		vfin_c = (vraw_c < glvis_pkg::VISC_FLOOR) ? glvis_pkg::VISC_FLOOR : vraw_c;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visc_valid_q <= 1'b0;
		end else if (en) begin
			visc_valid_q <= ex_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			visc_q.viscosity   <= vfin_c;
			visc_q.density_out <= density_q;
		end
	end

	assign visc_valid = visc_valid_q;
	assign visc       = visc_q;

`ifndef SYNTHESIS
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		visc_valid |-> visc.viscosity >= glvis_pkg::VISC_FLOOR)
		else $error("viscosity below floor");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		grad_stall == (visc_valid && visc_stall))
		else $error("input stall not tied to held output");

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		la_valid == lii_valid)
		else $error("log2 lanes out of step");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ex_valid && ipm6_c >= 21'sd18) |=> visc.viscosity == glvis_pkg::VISC_MAX)
		else $error("large exponent not saturated");
`endif

endmodule
